>>> hw/rtl/mlmc_gbm_euler_level_estimator_macros.svh
// Assertion helpers shared by the estimator.
`ifndef MLMC_GBM_EULER_LEVEL_ESTIMATOR_MACROS_SVH
`define MLMC_GBM_EULER_LEVEL_ESTIMATOR_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define MGELE_ASSERT_SAME(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MGELE_ASSERT_NEXT(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error(msg);

`endif

>>> hw/rtl/mgele_pkg.sv
`default_nettype none

package mgele_pkg;

  localparam int MAX_LEVEL = 10;
  localparam int LEVEL_W   = 4;
  localparam int STEP_W    = MAX_LEVEL + 1;
  localparam int PATH_W    = 25;
  localparam int PRICE_W   = 48;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 48;
  localparam int IN_DW     = 32;
  localparam int OUT_DW    = 480;

  localparam logic [63:0] PRICE_MAX = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [CFG_AW-1:0] CFG_LEVEL       = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_INIT_PRICE  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_STRIKE      = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_RATE_STEP   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_VOLATILITY  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_SQRT_STEP   = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_DISCOUNT    = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_NUM_SAMPLES = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DW, OP_TF, OP_FINE, OP_TC, OP_COARSE, OP_STEP,
    OP_PF, OP_PC, OP_Y2, OP_Y3, OP_Y4, OP_F2, OP_ACC
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DW, ST_TF, ST_FINE, ST_TC, ST_COARSE, ST_STEP,
    ST_PF, ST_PC, ST_Y2, ST_Y3, ST_Y4, ST_F2, ST_ACC
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_start;
    logic   save;
    logic   in_ready;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic path_end;
    logic coarse_step;
    logic out_full;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/mgele_mul.sv
`default_nettype none

module mgele_mul import mgele_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [63:0]        a,
  input  wire logic [63:0]        b,
  input  wire logic               sh24,
  input  wire logic               cap_price,
  input  wire logic               neg,
  output logic                    done,
  output logic signed [63:0]      res
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy, fin, sh24_r, capp_r, neg_r;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] ppx, rnd, q, capv;
  logic [63:0]  m;

  assign ah = cnt[1] ? a_r[63:32] : a_r[31:0];
  assign bh = cnt[0] ? b_r[63:32] : b_r[31:0];
  assign pp = ah * bh;

  always_comb begin
    case (cnt)
      2'd0:    ppx = {64'd0, pp};
      2'd3:    ppx = {pp, 64'd0};
      default: ppx = {32'd0, pp, 32'd0};
    endcase
    rnd  = acc + (sh24_r ? (128'd1 << 23) : (128'd1 << 27));
    q    = sh24_r ? (rnd >> 24) : (rnd >> 28);
    capv = capp_r ? {64'd0, PRICE_MAX} : {64'd0, MAG_MAX};
    m    = (q > capv) ? capv[63:0] : q[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      sh24_r <= sh24;
      capp_r <= cap_price;
      neg_r  <= neg;
      acc    <= 128'd0;
    end else if (busy) begin
      acc <= acc + ppx;
    end
    if (fin) begin
      res <= neg_r ? $signed(64'd0 - m) : $signed(m);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mgele_dp.sv
`default_nettype none

module mgele_dp import mgele_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CFG_AW-1:0]   cfg_addr,
  input  wire logic [CFG_DW-1:0]   cfg_data,
  input  wire logic [IN_DW-1:0]    in_data,
  input  wire logic                out_ready,
  input  wire cmd_t                cmd,
  output status_t                  status,
  output logic                     out_valid,
  output logic                     out_last,
  output logic [OUT_DW-1:0]        out_data
);

  logic [LEVEL_W-1:0]   level;
  logic [PRICE_W-1:0]   init_price, strike;
  logic signed [31:0]   rate_step;
  logic [30:0]          volatility, sqrt_step;
  logic [28:0]          discount;
  logic [PATH_W-1:0]    num_samples;

  logic [PRICE_W-1:0]   fine, coarse, pf;
  logic signed [31:0]   z, dw, ci;
  logic signed [63:0]   term, y2, y3, y4, f2;
  logic signed [47:0]   y;
  logic [STEP_W-1:0]    step;
  logic [PATH_W-1:0]    path;
  logic signed [63:0]   acc_d, acc_d3;
  logic [62:0]          acc_d2, acc_d4, acc_f, acc_f2;

  logic [47:0]          o_pf;
  logic signed [47:0]   o_y;
  logic signed [63:0]   o_d1, o_d3;
  logic [62:0]          o_d2, o_d4, o_f, o_f2;

  logic [LEVEL_W-1:0]   lv;
  logic                 lv_nz;
  logic [STEP_W:0]      nf, step_inc;
  logic signed [63:0]   rs64, dwc_wide;
  logic signed [31:0]   dwc;
  logic [63:0]          mul_a, mul_b;
  logic                 mul_sh24, mul_capp, mul_neg, mul_done;
  logic signed [63:0]   mul_res;
  logic [PATH_W-1:0]    path_inc;
  logic                 batch_end;
  logic signed [63:0]   sd_n, sd3_n;
  logic [62:0]          sd2_n, sd4_n, sf_n, sf2_n;
  logic signed [49:0]   ydiff;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic [PRICE_W-1:0] clampp(input logic [PRICE_W-1:0] p,
                                                input logic signed [63:0] d);
    logic signed [64:0] s;
    s = $signed({17'd0, p}) + {d[63], d};
    if (s[64]) clampp = '0;
    else if (s > $signed({1'b0, PRICE_MAX})) clampp = PRICE_MAX[PRICE_W-1:0];
    else clampp = s[PRICE_W-1:0];
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sadd64 = s[64] ? 64'sh8000_0000_0000_0000 : $signed(MAG_MAX);
    else sadd64 = s[63:0];
  endfunction

  function automatic logic [62:0] uadd63(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    uadd63 = s[63] ? MAG_MAX[62:0] : s[62:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= '0;
      init_price  <= 48'd1677721600;
      strike      <= 48'd1677721600;
      rate_step   <= '0;
      volatility  <= 31'd53687091;
      sqrt_step   <= 31'd268435456;
      discount    <= 29'd255343706;
      num_samples <= 25'd1000;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LEVEL:       level       <= cfg_data[LEVEL_W-1:0];
        CFG_INIT_PRICE:  init_price  <= cfg_data[PRICE_W-1:0];
        CFG_STRIKE:      strike      <= cfg_data[PRICE_W-1:0];
        CFG_RATE_STEP:   rate_step   <= cfg_data[31:0];
        CFG_VOLATILITY:  volatility  <= cfg_data[30:0];
        CFG_SQRT_STEP:   sqrt_step   <= cfg_data[30:0];
        CFG_DISCOUNT:    discount    <= cfg_data[28:0];
        CFG_NUM_SAMPLES: num_samples <= cfg_data[PATH_W-1:0];
        default: ;
      endcase
    end
  end

  assign lv       = (level > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : level;
  assign lv_nz    = (lv != '0);
  assign nf       = (STEP_W+1)'(1) << lv;
  assign step_inc = {1'b0, step} + (STEP_W+1)'(1);
  assign rs64     = {{32{rate_step[31]}}, rate_step};
  assign dwc_wide = {{32{ci[31]}}, ci} + {{32{dw[31]}}, dw};
  assign dwc      = sat32(dwc_wide);

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_sh24 = 1'b0;
    mul_capp = 1'b0;
    mul_neg  = 1'b0;
    case (cmd.op)
      OP_DW: begin
        mul_a   = {33'd0, sqrt_step};
        mul_b   = mag64({{32{z[31]}}, z});
        mul_neg = z[31];
      end
      OP_TF: begin
        mul_a   = {33'd0, volatility};
        mul_b   = mag64({{32{dw[31]}}, dw});
        mul_neg = dw[31];
      end
      OP_FINE: begin
        mul_a   = {16'd0, fine};
        mul_b   = mag64(term);
        mul_neg = term[63];
      end
      OP_TC: begin
        mul_a   = {33'd0, volatility};
        mul_b   = mag64({{32{dwc[31]}}, dwc});
        mul_neg = dwc[31];
      end
      OP_COARSE: begin
        mul_a   = {16'd0, coarse};
        mul_b   = mag64(term);
        mul_neg = term[63];
      end
      OP_PF: begin
        mul_a    = (fine > strike) ? {16'd0, fine - strike} : 64'd0;
        mul_b    = {35'd0, discount};
        mul_capp = 1'b1;
      end
      OP_PC: begin
        mul_a    = (lv_nz && coarse > strike) ? {16'd0, coarse - strike} : 64'd0;
        mul_b    = {35'd0, discount};
        mul_capp = 1'b1;
      end
      OP_Y2: begin
        mul_a    = mag64({{16{y[47]}}, y});
        mul_b    = mag64({{16{y[47]}}, y});
        mul_sh24 = 1'b1;
      end
      OP_Y3: begin
        mul_a    = y2;
        mul_b    = mag64({{16{y[47]}}, y});
        mul_sh24 = 1'b1;
        mul_neg  = y[47];
      end
      OP_Y4: begin
        mul_a    = y2;
        mul_b    = y2;
        mul_sh24 = 1'b1;
      end
      OP_F2: begin
        mul_a    = {16'd0, pf};
        mul_b    = {16'd0, pf};
        mul_sh24 = 1'b1;
      end
      default: ;
    endcase
  end

  mgele_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mul_start),
    .a         (mul_a),
    .b         (mul_b),
    .sh24      (mul_sh24),
    .cap_price (mul_capp),
    .neg       (mul_neg),
    .done      (mul_done),
    .res       (mul_res)
  );

  assign ydiff     = $signed({2'b00, pf}) - $signed({2'b00, mul_res[47:0]});
  assign path_inc  = path + PATH_W'(1);
  assign batch_end = (path_inc >= num_samples);
  assign sd_n      = sadd64(acc_d, {{16{y[47]}}, y});
  assign sd2_n     = uadd63(acc_d2, y2[62:0]);
  assign sd3_n     = sadd64(acc_d3, y3);
  assign sd4_n     = uadd63(acc_d4, y4[62:0]);
  assign sf_n      = uadd63(acc_f, {15'd0, pf});
  assign sf2_n     = uadd63(acc_f2, f2[62:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      path      <= '0;
      acc_d     <= '0;
      acc_d2    <= '0;
      acc_d3    <= '0;
      acc_d4    <= '0;
      acc_f     <= '0;
      acc_f2    <= '0;
      out_valid <= 1'b0;
      fine      <= 48'd1677721600;
      coarse    <= 48'd1677721600;
      ci        <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.save) begin
        case (cmd.op)
          OP_LOAD: begin
            z <= in_data[31:0];
            if (step == '0) begin
              fine   <= init_price;
              coarse <= init_price;
              ci     <= '0;
            end
          end
          OP_DW:  dw   <= sat32(mul_res);
          OP_TF:  term <= rs64 + mul_res;
          OP_FINE: begin
            fine <= clampp(fine, mul_res);
            if (lv_nz && !step[0]) begin
              ci <= dw;
            end
          end
          OP_TC:  term <= (rs64 <<< 1) + mul_res;
          OP_COARSE: begin
            coarse <= clampp(coarse, mul_res);
            ci     <= '0;
          end
          OP_STEP: step <= (step_inc >= nf) ? '0 : step_inc[STEP_W-1:0];
          OP_PF:  pf <= mul_res[47:0];
          OP_PC: begin
            if (ydiff > 50'sh0_7FFF_FFFF_FFFF) y <= 48'sh7FFF_FFFF_FFFF;
            else if (ydiff < -50'sh0_8000_0000_0000) y <= 48'sh8000_0000_0000;
            else y <= ydiff[47:0];
          end
          OP_Y2:  y2 <= mul_res;
          OP_Y3:  y3 <= mul_res;
          OP_Y4:  y4 <= mul_res;
          OP_F2:  f2 <= mul_res;
          OP_ACC: begin
            out_valid <= 1'b1;
            if (batch_end) begin
              path   <= '0;
              acc_d  <= '0;
              acc_d2 <= '0;
              acc_d3 <= '0;
              acc_d4 <= '0;
              acc_f  <= '0;
              acc_f2 <= '0;
            end else begin
              path   <= path_inc;
              acc_d  <= sd_n;
              acc_d2 <= sd2_n;
              acc_d3 <= sd3_n;
              acc_d4 <= sd4_n;
              acc_f  <= sf_n;
              acc_f2 <= sf2_n;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save && cmd.op == OP_ACC) begin
      o_pf     <= pf;
      o_y      <= y;
      o_d1     <= sd_n;
      o_d2     <= sd2_n;
      o_d3     <= sd3_n;
      o_d4     <= sd4_n;
      o_f      <= sf_n;
      o_f2     <= sf2_n;
      out_last <= batch_end;
    end
  end

  assign out_data = {4'd0, o_f2, o_f, o_d4, o_d3, o_d2, o_d1, o_y, o_pf};

  assign status.mul_done    = mul_done;
  assign status.path_end    = (step_inc >= nf);
  assign status.coarse_step = lv_nz & step[0];
  assign status.out_full    = out_valid;

endmodule

`default_nettype wire

>>> hw/rtl/mgele_ctrl.sv
`default_nettype none

module mgele_ctrl import mgele_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire status_t status,
  output cmd_t         cmd,
  output state_t       state
);

  state_t state_next;
  logic   issued, issued_next;
  logic   mul_state;

  assign mul_state = (state != ST_IDLE) && (state != ST_STEP) && (state != ST_ACC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  always_comb begin
    state_next  = state;
    issued_next = mul_state && !status.mul_done;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DW;
      ST_DW:     if (status.mul_done) state_next = ST_TF;
      ST_TF:     if (status.mul_done) state_next = ST_FINE;
      ST_FINE:   if (status.mul_done) state_next = status.coarse_step ? ST_TC : ST_STEP;
      ST_TC:     if (status.mul_done) state_next = ST_COARSE;
      ST_COARSE: if (status.mul_done) state_next = ST_STEP;
      ST_STEP:   state_next = status.path_end ? ST_PF : ST_IDLE;
      ST_PF:     if (status.mul_done) state_next = ST_PC;
      ST_PC:     if (status.mul_done) state_next = ST_Y2;
      ST_Y2:     if (status.mul_done) state_next = ST_Y3;
      ST_Y3:     if (status.mul_done) state_next = ST_Y4;
      ST_Y4:     if (status.mul_done) state_next = ST_F2;
      ST_F2:     if (status.mul_done) state_next = ST_ACC;
      ST_ACC:    if (!status.out_full) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.in_ready  = (state == ST_IDLE);
    cmd.mul_start = mul_state && !issued;
    cmd.save      = 1'b0;
    cmd.op        = OP_NONE;
    case (state)
      ST_IDLE: begin
        cmd.op   = OP_LOAD;
        cmd.save = in_valid;
      end
      ST_DW:     cmd.op = OP_DW;
      ST_TF:     cmd.op = OP_TF;
      ST_FINE:   cmd.op = OP_FINE;
      ST_TC:     cmd.op = OP_TC;
      ST_COARSE: cmd.op = OP_COARSE;
      ST_STEP: begin
        cmd.op   = OP_STEP;
        cmd.save = 1'b1;
      end
      ST_PF:     cmd.op = OP_PF;
      ST_PC:     cmd.op = OP_PC;
      ST_Y2:     cmd.op = OP_Y2;
      ST_Y3:     cmd.op = OP_Y3;
      ST_Y4:     cmd.op = OP_Y4;
      ST_F2:     cmd.op = OP_F2;
      ST_ACC: begin
        cmd.op   = OP_ACC;
        cmd.save = !status.out_full;
      end
      default:   cmd.op = OP_NONE;
    endcase
    if (mul_state) begin
      cmd.save = status.mul_done;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mlmc_gbm_euler_level_estimator.sv
// Channel   Direction  Word
// s_*       in         tdata[31:0] normal_sample
// m_*       out        tdata fields below, tlast = batch_done
// cfg_*     in         register write, index 0..7, data up to 48 bits
//
// Every product goes through one shared 32x32 multiplier as four partial
// products, with a start step before them and a rounding step after.
// A draw runs the fine-path products, and the coarse-path products too when it
// also moves the coarse path; a draw that ends a path adds payoffs, powers and sums.
// Reset is synchronous; no clearing pass is needed.
// A finished word waits in the output register; a second one stalls the input until it leaves.
`default_nettype none

`include "mlmc_gbm_euler_level_estimator_macros.svh"

module mlmc_gbm_euler_level_estimator import mgele_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CFG_AW-1:0]   cfg_addr,
  input  wire logic [CFG_DW-1:0]   cfg_data,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // normal_sample[31:0]
  input  wire logic [IN_DW-1:0]    s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // fine_payoff, payoff_difference, sum_diff, sum_diff_sq, sum_diff_cube,
  // sum_diff_fourth, sum_fine, sum_fine_sq, zero padding (lowest bit up)
  output logic [OUT_DW-1:0]        m_tdata,
  output logic                     m_tlast
);

  cmd_t    cmd;
  status_t status;
  state_t  state;

  mgele_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  mgele_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_last  (m_tlast),
    .out_data  (m_tdata)
  );

  assign s_tready = cmd.in_ready;

  `MGELE_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "accepted a word while busy")
  `MGELE_ASSERT_NEXT(a_result_shown, clk, rst, state == ST_ACC && !status.out_full, m_tvalid, "finished path not presented")
  `MGELE_ASSERT_SAME(a_no_accept_in_mul, clk, rst, status.mul_done, !s_tready, "multiplier result outside a product step")

endmodule

`default_nettype wire
